[hdl/b85_pkg.sv]
// Shared types, constants and helper functions for the base-85 group encoder.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package b85_pkg;

   localparam int JOB_QUEUE_DEPTH = 4;
   localparam int JOB_PTR_W       = 2;

   localparam logic [31:0] RECIP85_MUL = 32'hC0C0C0C1;
   localparam int          RECIP85_SHR = 38;

   localparam logic [6:0] CHAR_Z     = 7'h7A;
   localparam logic [6:0] CHAR_BANG  = 7'h21;
   localparam logic [6:0] DIGIT_BASE = 7'd33;

   localparam logic [3:0] PREFIX_LAST = 4'd9;
   localparam logic [3:0] MARKER_LAST = 4'd2;
   localparam logic [3:0] DIGITS_LAST = 4'd4;

   typedef logic [6:0] digit_type;

   typedef struct packed {
      logic        prefix;
      logic        marker;
      logic        group;
      logic        last;
      logic [31:0] value;
   } job_type;

   typedef struct packed {
      job_type              job;
      logic [4:0][6:0]      digits;
   } conv_job_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_RUN,
      CONV_HOLD
   } conv_state_type;

   typedef enum logic [1:0] {
      EMIT_IDLE,
      EMIT_PREFIX,
      EMIT_MARKER,
      EMIT_DIGITS
   } emit_state_type;

   // Exact quotient by 85 for any 32-bit value.
   function automatic logic [31:0] recip85(input logic [31:0] x);
      logic [63:0] prod;
      prod = {32'd0, x} * {32'd0, RECIP85_MUL};
      return {6'd0, prod[63:RECIP85_SHR]};
   endfunction

   function automatic logic [6:0] prefix_char(input logic [3:0] idx);
      logic [6:0] ch;
      case (idx)
         4'd0: ch = 7'h4C;
         4'd1: ch = 7'h50;
         4'd2: ch = 7'h48;
         4'd3: ch = 7'h2B;
         4'd4: ch = 7'h6D;
         4'd5: ch = 7'h30;
         4'd6: ch = 7'h3C;
         4'd7: ch = 7'h58;
         4'd8: ch = 7'h3B;
         default: ch = CHAR_Z;
      endcase
      return ch;
   endfunction

endpackage
`default_nettype wire

[hdl/base85_group_encoder_unit.sv]
// Top level of the base-85 group encoder: front end, job queue, converter, emitter.
// Depends on b85_pkg and the modules b85_front, b85_queue, b85_convert, b85_emit.
//
//   Channel  Direction  Word
//   req_     in         one raw byte plus last-byte flag
//   rsp_     out        one ASCII character plus run-last and stream-end flags
//
// At most one character leaves per cycle. The converter loads each group and then derives
// its digits one after another from a single 32-bit reciprocal multiplier; a marker may
// lead a group. The ten prefix characters are sent at the start of a stream. Reset is
// synchronous and needs no clearing pass. Input and output stall independently; the
// four-entry job queue absorbs the difference.
`default_nettype none
module base85_group_encoder_unit import b85_pkg::*; #(
   parameter int MARKER_GROUPS = 15
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_is_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [6:0]      rsp_out_char,
   output logic            rsp_run_last,
   output logic            rsp_stream_end
);

   logic         queue_full;
   logic         push_valid;
   job_type      push_job;
   logic         pop_valid;
   logic         pop_stall;
   job_type      pop_job;
   logic         conv_valid;
   logic         conv_stall;
   conv_job_type conv_data;

   b85_front #(
      .MARKER_GROUPS(MARKER_GROUPS)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_is_last_byte (req_is_last_byte),
      .queue_full       (queue_full),
      .push_valid       (push_valid),
      .push_job         (push_job)
   );

   b85_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_job   (push_job),
      .full       (queue_full),
      .pop_valid  (pop_valid),
      .pop_stall  (pop_stall),
      .pop_job    (pop_job)
   );

   b85_convert u_convert (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pop_valid),
      .in_stall  (pop_stall),
      .in_job    (pop_job),
      .out_valid (conv_valid),
      .out_stall (conv_stall),
      .out_data  (conv_data)
   );

   b85_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (conv_valid),
      .in_stall       (conv_stall),
      .in_data        (conv_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_run_last   (rsp_run_last),
      .rsp_stream_end (rsp_stream_end)
   );

endmodule
`default_nettype wire

[hdl/b85_front.sv]
// Front end: accepts bytes, gathers groups and decides what each byte must emit.
// Depends on b85_pkg for the job descriptor.
`default_nettype none
module b85_front import b85_pkg::*; #(
   parameter int MARKER_GROUPS = 15
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_in_byte,
   input  wire logic        req_is_last_byte,
   input  wire logic        queue_full,
   output logic             push_valid,
   output job_type          push_job
);

   localparam int PHASE_W = (MARKER_GROUPS > 1) ? $clog2(MARKER_GROUPS) : 1;

   logic [23:0]        word_ff, word_in;
   logic [1:0]         count_ff, count_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic               any_done_ff, any_done_in;
   logic               started_ff, started_in;

   logic accept;
   logic complete;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign complete  = (count_ff == 2'd3) || req_is_last_byte;

   always_comb begin
      push_job.prefix = !started_ff;
      push_job.marker = complete && any_done_ff && (phase_ff == '0);
      push_job.group  = complete;
      push_job.last   = req_is_last_byte;
      case (count_ff)
         2'd0:    push_job.value = {req_in_byte, 24'd0};
         2'd1:    push_job.value = {word_ff[7:0], req_in_byte, 16'd0};
         2'd2:    push_job.value = {word_ff[15:0], req_in_byte, 8'd0};
         default: push_job.value = {word_ff, req_in_byte};
      endcase
      push_valid = req_valid && (complete || !started_ff);
   end

   always_comb begin
      word_in     = word_ff;
      count_in    = count_ff;
      phase_in    = phase_ff;
      any_done_in = any_done_ff;
      started_in  = started_ff;
      if (accept) begin
         started_in = 1'b1;
         if (complete) begin
            word_in     = '0;
            count_in    = '0;
            any_done_in = 1'b1;
            phase_in    = (phase_ff == PHASE_W'(MARKER_GROUPS - 1)) ? '0 : phase_ff + 1'b1;
         end else begin
            word_in  = {word_ff[15:0], req_in_byte};
            count_in = count_ff + 1'b1;
         end
         if (req_is_last_byte) begin
            word_in     = '0;
            count_in    = '0;
            phase_in    = '0;
            any_done_in = 1'b0;
            started_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff     <= '0;
         count_ff    <= '0;
         phase_ff    <= '0;
         any_done_ff <= 1'b0;
         started_ff  <= 1'b0;
      end else begin
         word_ff     <= word_in;
         count_ff    <= count_in;
         phase_ff    <= phase_in;
         any_done_ff <= any_done_in;
         started_ff  <= started_in;
      end
   end

endmodule
`default_nettype wire

[hdl/b85_queue.sv]
// Short queue of job descriptors between the front end and the back end.
// Depends on b85_pkg for the job type and the queue depth.
`default_nettype none
module b85_queue import b85_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   input  wire job_type push_job,
   output logic         full,
   output logic         pop_valid,
   input  wire logic    pop_stall,
   output job_type      pop_job
);

   job_type              mem_ff [JOB_QUEUE_DEPTH];
   logic [JOB_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [JOB_PTR_W:0]   count_ff, count_in;
   logic                 push, pop;

   assign full      = (count_ff == (JOB_PTR_W + 1)'(JOB_QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_job   = mem_ff[rd_ptr_ff];
   assign push      = push_valid && !full;
   assign pop       = pop_valid && !pop_stall;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

endmodule
`default_nettype wire

[hdl/b85_convert.sv]
// Iterative base-85 conversion of one group, one digit per cycle, least significant first.
// Depends on b85_pkg for the job types, the state type and the reciprocal function.
`default_nettype none
module b85_convert import b85_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire job_type in_job,
   output logic         out_valid,
   input  wire logic    out_stall,
   output conv_job_type out_data
);

   conv_state_type  state_ff, state_in;
   logic [2:0]      step_ff, step_in;
   job_type         job_ff;
   logic [4:0][6:0] digits_ff;
   logic [6:0]      x_ff;
   logic [31:0]     q_ff, q_in;
   logic [31:0]     mul_src;
   logic [6:0]      q_low;
   logic [6:0]      digit;
   logic            take;
   conv_state_type  start_state;

   assign take        = in_valid && !in_stall;
   assign start_state = in_job.group ? CONV_RUN : CONV_HOLD;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CONV_IDLE: begin
            if (in_valid) begin
               state_in = start_state;
            end
         end
         CONV_RUN: begin
            if (step_ff == 3'd4) begin
               state_in = CONV_HOLD;
            end
         end
         CONV_HOLD: begin
            if (!out_stall) begin
               state_in = in_valid ? start_state : CONV_IDLE;
            end
         end
         default: state_in = CONV_IDLE;
      endcase
   end

   always_comb begin
      in_stall = !((state_ff == CONV_IDLE) || ((state_ff == CONV_HOLD) && !out_stall));
      out_valid = (state_ff == CONV_HOLD);
      out_data.job    = job_ff;
      out_data.digits = digits_ff;
   end

   assign mul_src = take ? in_job.value : q_ff;
   assign q_in    = recip85(mul_src);
   assign q_low   = q_ff[6:0];
   assign digit   = x_ff - ((q_low << 6) + (q_low << 4) + (q_low << 2) + q_low);

   always_comb begin
      step_in = step_ff;
      if (take) begin
         step_in = '0;
      end else if (state_ff == CONV_RUN) begin
         step_in = step_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= in_job;
         x_ff   <= in_job.value[6:0];
         q_ff   <= q_in;
      end else if (state_ff == CONV_RUN) begin
         digits_ff <= {digits_ff[3:0], digit};
         x_ff      <= q_ff[6:0];
         q_ff      <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

[hdl/b85_emit.sv]
// Character sequencer: sends prefix, marker and digit characters one word per cycle unless rsp_stall holds it.
// Depends on b85_pkg for the job types, the state type and the character constants.
`default_nettype none
module b85_emit import b85_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_stall,
   input  wire conv_job_type in_data,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic [6:0]        rsp_out_char,
   output logic              rsp_run_last,
   output logic              rsp_stream_end
);

   emit_state_type state_ff, state_in;
   logic [3:0]     idx_ff, idx_in;
   conv_job_type   data_ff;
   emit_state_type start_state;
   emit_state_type follow_state;
   logic           seg_end;
   logic           char_last;
   logic           advance;

   assign advance = (state_ff != EMIT_IDLE) && !rsp_stall;

   always_comb begin
      if (in_data.job.prefix) begin
         start_state = EMIT_PREFIX;
      end else if (in_data.job.marker) begin
         start_state = EMIT_MARKER;
      end else begin
         start_state = EMIT_DIGITS;
      end
   end

   always_comb begin
      seg_end      = 1'b0;
      follow_state = EMIT_IDLE;
      rsp_out_char = DIGIT_BASE + data_ff.digits[idx_ff[2:0]];
      case (state_ff)
         EMIT_PREFIX: begin
            seg_end      = (idx_ff == PREFIX_LAST);
            rsp_out_char = prefix_char(idx_ff);
            if (data_ff.job.marker) begin
               follow_state = EMIT_MARKER;
            end else if (data_ff.job.group) begin
               follow_state = EMIT_DIGITS;
            end
         end
         EMIT_MARKER: begin
            seg_end      = (idx_ff == MARKER_LAST);
            rsp_out_char = (idx_ff == '0) ? CHAR_Z : CHAR_BANG;
            if (data_ff.job.group) begin
               follow_state = EMIT_DIGITS;
            end
         end
         EMIT_DIGITS: begin
            seg_end = (idx_ff == DIGITS_LAST);
         end
         default: begin
            seg_end = 1'b0;
         end
      endcase
      char_last      = seg_end && (follow_state == EMIT_IDLE);
      rsp_valid      = (state_ff != EMIT_IDLE);
      rsp_run_last   = char_last;
      rsp_stream_end = char_last && data_ff.job.last;
      in_stall       = !((state_ff == EMIT_IDLE) || (advance && char_last));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         EMIT_IDLE: begin
            if (in_valid) begin
               state_in = start_state;
            end
         end
         EMIT_PREFIX, EMIT_MARKER, EMIT_DIGITS: begin
            if (advance && seg_end) begin
               if (!char_last) begin
                  state_in = follow_state;
               end else begin
                  state_in = in_valid ? start_state : EMIT_IDLE;
               end
            end
         end
         default: state_in = EMIT_IDLE;
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (advance) begin
         idx_in = seg_end ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && !in_stall) begin
         data_ff <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EMIT_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

endmodule
`default_nettype wire
